// File: rtl/crar_pkg.sv
`default_nettype none

package crar_pkg;

  // field widths
  localparam int WORD_W = 32;
  localparam int MODE_W = 3;

  // mixer digit size: one 8-bit digit of the multiplier per cycle
  localparam int DIGIT_W = 8;
  localparam int DIGITS  = WORD_W / DIGIT_W;
  localparam int CNT_W   = $clog2(DIGITS);

  // mixer constants
  localparam logic [WORD_W-1:0] MIX_K1   = 32'h7feb352d;
  localparam logic [WORD_W-1:0] MIX_K2   = 32'h846ca68b;
  localparam int                MIX_SH_A = 16;
  localparam int                MIX_SH_B = 15;

  // seed / salt constants
  localparam logic [WORD_W-1:0] KEY_BASE    = 32'h13579bdf;
  localparam logic [WORD_W-1:0] KEY_STEP    = 32'h00001021;
  localparam logic [WORD_W-1:0] SALT_PASS   = 32'ha5a55a5a;
  localparam logic [WORD_W-1:0] SALT_SYNTH  = 32'h5aa5f00d;
  localparam logic [WORD_W-1:0] SALT_REPLAY = 32'hdeadbeef;
  localparam logic [WORD_W-1:0] SALT_STALE  = 32'h2468ace0;
  localparam logic [WORD_W-1:0] SYNTH_OFS   = 32'h00000007;
  localparam logic [WORD_W-1:0] FAIL_WORD   = 32'hffffffff;

  // operating modes
  localparam logic [MODE_W-1:0] MODE_PASS   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SYNTH  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REPLAY = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STALE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FAIL   = 3'd4;

  // commands
  localparam logic CMD_ISSUE   = 1'b0;
  localparam logic CMD_RESPOND = 1'b1;

endpackage

`default_nettype wire

// File: rtl/crar_if.sv
`default_nettype none

// command channel
interface crar_in_if import crar_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [WORD_W-1:0] operand;

  modport source (output valid, output command, output operand, input ready);
  modport sink   (input valid, input command, input operand, output ready);
endinterface

// result channel
interface crar_out_if import crar_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] result_word;
  logic              accepted;
  logic [WORD_W-1:0] failures;

  modport source (output valid, output result_word, output accepted, output failures,
                  input ready);
  modport sink   (input valid, input result_word, input accepted, input failures,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/crar_mixer.sv
`default_nettype none

// xor-shift-multiply mixer; each constant multiply runs one digit per cycle
module crar_mixer import crar_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] din,
  output logic                   done,
  output logic [WORD_W-1:0]      dout
);

  typedef enum logic [1:0] {M_IDLE, M_MUL1, M_MUL2} mix_state_t;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);

  mix_state_t          state_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [WORD_W-1:0]   a_r;      // multiplier, shifted right a digit per cycle
  logic [WORD_W-1:0]   mcand_r;  // constant, shifted left a digit per cycle
  logic [WORD_W-1:0]   acc_r;
  logic [WORD_W-1:0]   dout_r;
  logic                done_r;

  logic [WORD_W-1:0]   prod;
  logic [WORD_W-1:0]   acc_sum;

  // one partial product per cycle, kept modulo 2^32
  assign prod    = mcand_r * a_r[DIGIT_W-1:0];
  assign acc_sum = acc_r + prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      // done is registered: it pulses once the last digit of the second multiply is taken, with dout
      done_r <= (state_r == M_MUL2) && (cnt_r == CNT_LAST);
      case (state_r)
        M_IDLE: begin
          if (start) begin
            a_r     <= din ^ (din >> MIX_SH_A);
            mcand_r <= MIX_K1;
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= M_MUL1;
          end
        end
        M_MUL1: begin
          if (cnt_r == CNT_LAST) begin
            a_r     <= acc_sum ^ (acc_sum >> MIX_SH_B);
            mcand_r <= MIX_K2;
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= M_MUL2;
          end else begin
            acc_r   <= acc_sum;
            a_r     <= a_r >> DIGIT_W;
            mcand_r <= mcand_r << DIGIT_W;
            cnt_r   <= cnt_r + 1'b1;
          end
        end
        M_MUL2: begin
          if (cnt_r == CNT_LAST) begin
            dout_r  <= acc_sum ^ (acc_sum >> MIX_SH_A);
            state_r <= M_IDLE;
          end else begin
            acc_r   <= acc_sum;
            a_r     <= a_r >> DIGIT_W;
            mcand_r <= mcand_r << DIGIT_W;
            cnt_r   <= cnt_r + 1'b1;
          end
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign dout = dout_r;

endmodule

`default_nettype wire

// File: rtl/challenge_response_auth_responder_core.sv
// Challenge-response responder.
// in_if   : command transfers (command 0 issues a challenge from operand as
//           seed, command 1 responds to the challenge in operand).
// out_if  : one result transfer per command: result_word, accepted, failures.
// cfg_*   : cfg_wr_en writes op_mode from cfg_wr_data; write only when idle.
// One command is in work at a time. Items that need the mixer take its two
// 32x32 constant multiplies at one 8-bit digit per cycle; the result is
// loaded once the mixer reports done, and the next command is taken only
// after that load. Items answered from stored words (stale repeat, replay,
// force fail, unknown mode) go to the load state directly, skipping the
// mixer, and likewise take no new command before their result is loaded.
// The result register is separate from the work state: a new command is
// taken while a result still waits; if the receiver stalls with a result
// pending, the next result holds in the load state and in_if.ready stays low.
// Reset (rst_n low, synchronous) clears all counters, stored words, the mode
// register and the valid flag.
`default_nettype none

module challenge_response_auth_responder_core import crar_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  crar_in_if.sink                in_if,
  crar_out_if.source             out_if,
  input  wire logic              cfg_wr_en,
  input  wire logic [MODE_W-1:0] cfg_wr_data
);

  typedef enum logic [1:0] {S_IDLE, S_HASH, S_LOAD} state_t;

  state_t            state_r;
  logic [MODE_W-1:0] op_mode_r;
  logic [WORD_W-1:0] issue_count_r;
  logic [WORD_W-1:0] issue_key_r;     // KEY_BASE + issue_count * KEY_STEP
  logic [WORD_W-1:0] synth_count_r;
  logic [WORD_W-1:0] replay_total_r;
  logic [WORD_W-1:0] fail_total_r;
  logic [WORD_W-1:0] prior_chal_r;
  logic [WORD_W-1:0] prior_resp_r;

  // item in work
  logic              cmd_r;
  logic [WORD_W-1:0] word_r;
  logic              ok_r;
  logic              fail_base_r;
  logic              upd_chal_r;

  // result register
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic              out_ok_r;
  logic [WORD_W-1:0] out_fail_r;

  // accept decode
  logic              in_fire;
  logic [WORD_W-1:0] key_nxt;
  logic              need_hash_nxt;
  logic [WORD_W-1:0] hash_in_nxt;
  logic [WORD_W-1:0] word_nxt;
  logic              ok_nxt;
  logic              fail_base_nxt;

  // finalize
  logic              load_fire;
  logic              zero_fail;
  logic [1:0]        fail_add;
  logic [WORD_W-1:0] fail_total_nxt;

  logic              mix_done;
  logic [WORD_W-1:0] mix_dout;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign key_nxt     = issue_key_r + KEY_STEP;

  // decide what the command needs at transfer time
  always_comb begin
    need_hash_nxt = 1'b0;
    hash_in_nxt   = '0;
    word_nxt      = '0;
    ok_nxt        = 1'b0;
    fail_base_nxt = 1'b0;
    if (in_if.command == CMD_ISSUE) begin
      if (op_mode_r == MODE_STALE && prior_chal_r != '0) begin
        word_nxt = prior_chal_r;
      end else begin
        need_hash_nxt = 1'b1;
        hash_in_nxt   = in_if.operand ^ key_nxt;
      end
    end else begin
      ok_nxt = 1'b1;
      case (op_mode_r)
        MODE_PASS: begin
          need_hash_nxt = 1'b1;
          hash_in_nxt   = in_if.operand ^ SALT_PASS ^ issue_count_r;
        end
        MODE_SYNTH: begin
          need_hash_nxt = 1'b1;
          hash_in_nxt   = in_if.operand ^ SALT_SYNTH ^ (synth_count_r + SYNTH_OFS);
        end
        MODE_REPLAY: begin
          if (prior_resp_r != '0) begin
            word_nxt = prior_resp_r;
          end else begin
            need_hash_nxt = 1'b1;
            hash_in_nxt   = in_if.operand ^ SALT_REPLAY;
          end
        end
        MODE_STALE: begin
          need_hash_nxt = 1'b1;
          hash_in_nxt   = prior_chal_r ^ SALT_STALE;
        end
        MODE_FAIL: begin
          word_nxt      = FAIL_WORD;
          ok_nxt        = 1'b0;
          fail_base_nxt = 1'b1;
        end
        default: begin
          word_nxt      = '0;
          ok_nxt        = 1'b0;
          fail_base_nxt = 1'b1;
        end
      endcase
    end
  end

  crar_mixer u_mixer (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire && need_hash_nxt),
    .din   (hash_in_nxt),
    .done  (mix_done),
    .dout  (mix_dout)
  );

  // zero response check and failure count
  assign load_fire      = (state_r == S_LOAD) && (!out_valid_r || out_if.ready);
  assign zero_fail      = (cmd_r == CMD_RESPOND) && (op_mode_r != MODE_FAIL) &&
                          (word_r == '0);
  assign fail_add       = {1'b0, fail_base_r} + {1'b0, zero_fail};
  assign fail_total_nxt = fail_total_r + WORD_W'(fail_add);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      op_mode_r      <= MODE_PASS;
      issue_count_r  <= '0;
      issue_key_r    <= KEY_BASE;
      synth_count_r  <= '0;
      replay_total_r <= '0;
      fail_total_r   <= '0;
      prior_chal_r   <= '0;
      prior_resp_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        op_mode_r <= cfg_wr_data;
      end

      // output register: set on a load, cleared by a result transfer
      if (load_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cmd_r       <= in_if.command;
            word_r      <= word_nxt;
            ok_r        <= ok_nxt;
            fail_base_r <= fail_base_nxt;
            upd_chal_r  <= (in_if.command == CMD_ISSUE) && need_hash_nxt;
            if (in_if.command == CMD_ISSUE) begin
              issue_count_r <= issue_count_r + 1'b1;
              issue_key_r   <= key_nxt;
            end else if (op_mode_r == MODE_SYNTH) begin
              synth_count_r <= synth_count_r + 1'b1;
            end else if (op_mode_r == MODE_REPLAY) begin
              replay_total_r <= replay_total_r + 1'b1;
            end
            state_r <= need_hash_nxt ? S_HASH : S_LOAD;
          end
        end
        S_HASH: begin
          if (mix_done) begin
            word_r  <= mix_dout;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (load_fire) begin
            out_word_r   <= word_r;
            out_ok_r     <= ok_r && !zero_fail;
            out_fail_r   <= fail_total_nxt;
            fail_total_r <= fail_total_nxt;
            if (upd_chal_r) begin
              prior_chal_r <= word_r;
            end
            if (cmd_r == CMD_RESPOND) begin
              prior_resp_r <= word_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.result_word = out_word_r;
  assign out_if.accepted    = out_ok_r;
  assign out_if.failures    = out_fail_r;

`ifndef SYNTH
  // the mixer only finishes while an item waits for it
  a_mix_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
    mix_done |-> state_r == S_HASH)
    else $error("mixer finished outside hash wait");

  // a command transfer closes the input until its result is loaded
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_if.ready)
    else $error("second command taken while one is in work");

  // an accepted response is never zero
  a_accept_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.accepted) |-> out_if.result_word != '0)
    else $error("zero response flagged as accepted");

  // the failure count moves only when a result is loaded
  a_fail_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !load_fire |=> fail_total_r == $past(fail_total_r))
    else $error("failure count changed without a result");
`endif

endmodule

`default_nettype wire

// File: tb/sv/challenge_response_auth_responder_core_test.sv
`timescale 1ns / 1ps

module challenge_response_auth_responder_core_test import crar_pkg::*; ();

  // unknown modes at the two ends of the spare codes
  localparam logic [MODE_W-1:0] MODE_UNKNOWN_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNKNOWN_HI = 3'd7;

  // mixer and salt values, kept local so the check does not lean on the package
  localparam bit [31:0] K_MUL1   = 32'h7feb352d;
  localparam bit [31:0] K_MUL2   = 32'h846ca68b;
  localparam bit [31:0] K_SEED   = 32'h13579bdf;
  localparam bit [31:0] K_STEP   = 32'h00001021;
  localparam bit [31:0] K_PASS   = 32'ha5a55a5a;
  localparam bit [31:0] K_SYNTH  = 32'h5aa5f00d;
  localparam bit [31:0] K_REPLAY = 32'hdeadbeef;
  localparam bit [31:0] K_STALE  = 32'h2468ace0;
  localparam bit [31:0] K_OFS    = 32'd7;

  localparam int SETTLE_CYCLES  = 14;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 55;
  localparam int HOLD_CYCLES    = 400;

  typedef struct packed {
    logic        cmd;
    logic [31:0] word;
  } command_t;

  typedef struct packed {
    logic [31:0] word;
    logic        ok;
    logic [31:0] fails;
  } answer_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [MODE_W-1:0] cfg_wr_data;

  crar_in_if  in_ch ();
  crar_out_if out_ch ();

  challenge_response_auth_responder_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // commands waiting to go out, answers waiting to come back
  command_t command_q[$];
  answer_t  answer_q[$];

  // shadow of the responder state
  logic [MODE_W-1:0] mode_now;
  bit [31:0] n_issued, n_synth, n_fail, last_chal, last_resp;

  // counters as seen by the stimulus planner, ahead of acceptance
  bit [31:0] plan_issued, plan_synth;

  int unsigned err_cnt;
  int unsigned results_seen;
  int unsigned idle_cycles;
  logic in_took;

  function automatic bit [31:0] mix32(input bit [31:0] v);
    v = v ^ (v >> 16);
    v = v * K_MUL1;
    v = v ^ (v >> 15);
    v = v * K_MUL2;
    v = v ^ (v >> 16);
    return v;
  endfunction

  // advance the shadow state by one accepted command and queue its answer
  task automatic predict_answer(input logic cmd, input bit [31:0] word);
    answer_t   a;
    bit [31:0] res;
    bit        ok;
    ok = 1'b0;
    if (cmd == CMD_ISSUE) begin
      n_issued = n_issued + 1;
      if (mode_now == MODE_STALE && last_chal != 0) begin
        res = last_chal;
      end else begin
        res = mix32(word ^ (K_SEED + n_issued * K_STEP));
        last_chal = res;
      end
    end else begin
      ok = 1'b1;
      case (mode_now)
        MODE_PASS: res = mix32(word ^ K_PASS ^ n_issued);
        MODE_SYNTH: begin
          res = mix32(word ^ K_SYNTH ^ (n_synth + K_OFS));
          n_synth = n_synth + 1;
        end
        MODE_REPLAY: res = (last_resp != 0) ? last_resp : mix32(word ^ K_REPLAY);
        MODE_STALE: res = mix32(last_chal ^ K_STALE);
        MODE_FAIL: begin
          res = '1;
          ok = 1'b0;
          n_fail = n_fail + 1;
        end
        default: begin
          res = '0;
          ok = 1'b0;
          n_fail = n_fail + 1;
        end
      endcase
      // a zero response is always a rejection
      if (mode_now != MODE_FAIL && res == 0) begin
        ok = 1'b0;
        n_fail = n_fail + 1;
      end
      last_resp = res;
    end
    a.word  = res;
    a.ok    = ok;
    a.fails = n_fail;
    answer_q.push_back(a);
  endtask

  // operand zeroing the mixer input of the next issue or pass/synth/replay response
  function automatic bit [31:0] zero_word(input logic cmd);
    if (cmd == CMD_ISSUE) return K_SEED + (plan_issued + 1) * K_STEP;
    case (mode_now)
      MODE_PASS:   return K_PASS ^ plan_issued;
      MODE_SYNTH:  return K_SYNTH ^ (plan_synth + K_OFS);
      MODE_REPLAY: return K_REPLAY;
      default:     return $urandom;
    endcase
  endfunction

  function automatic bit [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'd1 << $urandom_range(0, 31);
      3:       return ~(32'd1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_item(input logic cmd, input bit [31:0] word);
    command_t c;
    c.cmd  = cmd;
    c.word = word;
    command_q.push_back(c);
    if (cmd == CMD_ISSUE) plan_issued = plan_issued + 1;
    else if (mode_now == MODE_SYNTH) plan_synth = plan_synth + 1;
  endtask

  // let the block drain, then give it time to finish any work in flight
  task automatic wait_idle();
    while (command_q.size() != 0 || in_ch.valid || answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic [MODE_W-1:0] m);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    mode_now    = m;
    plan_issued = n_issued;
    plan_synth  = n_synth;
  endtask

  // stimulus and run control
  initial begin
    logic c;
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_ISSUE;
    in_ch.operand  = '0;
    out_ch.ready   = 1'b0;
    mode_now       = MODE_PASS;
    {n_issued, n_synth, n_fail, last_chal, last_resp} = '0;
    plan_issued    = '0;
    plan_synth     = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // passthrough: seed extremes, an issue whose challenge is zero, response extremes
    set_mode(MODE_PASS);
    queue_item(CMD_ISSUE, '0);
    queue_item(CMD_ISSUE, '1);
    queue_item(CMD_ISSUE, zero_word(CMD_ISSUE));
    queue_item(CMD_RESPOND, '0);
    queue_item(CMD_RESPOND, '1);
    queue_item(CMD_RESPOND, zero_word(CMD_RESPOND));

    // stale: zero stored challenge forces a fresh hash, then a repeat
    set_mode(MODE_STALE);
    queue_item(CMD_ISSUE, $urandom);
    queue_item(CMD_ISSUE, $urandom);
    queue_item(CMD_RESPOND, $urandom);

    // synthetic, ending on a zero response so the stored response is zero
    set_mode(MODE_SYNTH);
    queue_item(CMD_RESPOND, $urandom);
    queue_item(CMD_RESPOND, zero_word(CMD_RESPOND));

    // replay: zero stored response with a zero hash, then fresh, then repeat
    set_mode(MODE_REPLAY);
    queue_item(CMD_RESPOND, K_REPLAY);
    queue_item(CMD_RESPOND, $urandom);
    queue_item(CMD_RESPOND, $urandom);

    set_mode(MODE_FAIL);
    queue_item(CMD_RESPOND, $urandom);
    queue_item(CMD_ISSUE, $urandom);

    set_mode(MODE_UNKNOWN_LO);
    queue_item(CMD_RESPOND, $urandom);
    set_mode(MODE_UNKNOWN_HI);
    queue_item(CMD_RESPOND, $urandom);
    queue_item(CMD_ISSUE, $urandom);

    // random phases, each under its own mode
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) set_mode(MODE_UNKNOWN_HI);
      else if (p == 1) set_mode(MODE_PASS);
      else set_mode(MODE_W'($urandom_range(0, 7)));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        c = 1'($urandom_range(0, 1));
        queue_item(c, ($urandom_range(0, 11) == 0) ? zero_word(c) : rand_operand());
      end
    end

    wait_idle();
    if (err_cnt == 0 && answer_q.size() == 0) begin
      $display("PASS challenge_response_auth_responder_core");
    end else begin
      $display("FAIL challenge_response_auth_responder_core");
    end
    $finish;
  end

  // command driver: bursts of transfers with random gaps
  command_t drv_item;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (command_q.size() != 0) begin
        drv_item = command_q.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.command <= drv_item.cmd;
        in_ch.operand <= drv_item.word;
        if (burst_left > 1) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver: shifting stall styles, plus one long hold-off under load
  int unsigned rx_tick = 0;
  int unsigned rx_style = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && results_seen >= 150 && command_q.size() > 20) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      rx_tick = rx_tick + 1;
      if (rx_tick % 64 == 0) rx_style = $urandom_range(0, 3);
      case (rx_style)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        2:       out_ch.ready <= (rx_tick % 4 == 0);
        default: out_ch.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // monitor: check result transfers, predict on command transfers, watchdog
  answer_t want;

  always @(posedge clk) begin
    in_took <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen = results_seen + 1;
        if (answer_q.size() == 0) begin
          $error("result transfer with no command outstanding");
          err_cnt = err_cnt + 1;
        end else begin
          want = answer_q.pop_front();
          if (out_ch.result_word !== want.word) begin
            $error("result_word: expected %h, got %h", want.word, out_ch.result_word);
            err_cnt = err_cnt + 1;
          end
          if (out_ch.accepted !== want.ok) begin
            $error("accepted: expected %b, got %b", want.ok, out_ch.accepted);
            err_cnt = err_cnt + 1;
          end
          if (out_ch.failures !== want.fails) begin
            $error("failures: expected %0d, got %0d", want.fails, out_ch.failures);
            err_cnt = err_cnt + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) predict_answer(in_ch.command, in_ch.operand);
    end

    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL challenge_response_auth_responder_core");
        $finish;
      end
    end
  end

endmodule

// File: files.f
rtl/crar_pkg.sv
rtl/crar_if.sv
rtl/crar_mixer.sv
rtl/challenge_response_auth_responder_core.sv
tb/sv/challenge_response_auth_responder_core_test.sv
